>>> design/bahc_pkg.sv
// shared types, register indexes and reset values for the baro altitude hold controller
// no dependencies; imported by bahc_law, baro_altitude_hold_controller and its test bench
`timescale 1ns / 1ps

package bahc_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;
  localparam int IN_DATA_W  = 40;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 32;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_KP         = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ERROR_BAND      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DESCENT_TRANS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FINAL_DESCENT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DESCENT     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COMP_LOW_LIMIT  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_COMP_HIGH_LIMIT = 3'd6;

  // register reset values
  localparam logic [7:0]         RST_GAIN_KP         = 8'd16;
  localparam logic [10:0]        RST_ERROR_BAND      = 11'd200;
  localparam logic [11:0]        RST_DESCENT_TRANS   = 12'd1000;
  localparam logic signed [11:0] RST_FINAL_DESCENT   = -12'sd50;
  localparam logic signed [11:0] RST_MAX_DESCENT     = -12'sd100;
  localparam logic signed [7:0]  RST_COMP_LOW_LIMIT  = -8'sd10;
  localparam logic signed [7:0]  RST_COMP_HIGH_LIMIT = 8'sd30;

  // descent counter ceiling and slew step
  localparam logic [2:0] CNT_MAX  = 3'd6;
  localparam int         SLEW_MAX = 2;

  typedef struct packed {
    logic [7:0]         gain_kp;
    logic [10:0]        error_band_cm;
    logic [11:0]        descent_transition_cm;
    logic signed [11:0] final_descent_rate;
    logic signed [11:0] max_descent_rate;
    logic signed [7:0]  comp_low_limit;
    logic signed [7:0]  comp_high_limit;
  } cfg_t;

  typedef struct packed {
    logic               throttle_moving;
    logic               holding_station;
    logic               return_hold_mode;
    logic               altitude_valid;
    logic               new_sample;
    logic signed [15:0] climb_rate;
    logic signed [15:0] altitude_cm;
  } item_t;

  typedef struct packed {
    logic signed [15:0] target_altitude;
    logic [2:0]         descent_counter;
    logic signed [7:0]  comp_value;
  } state_t;

endpackage

>>> design/bahc_law.sv
// hold law and mode selection: next controller state and hover flag for one tick
// depends on bahc_pkg
`timescale 1ns / 1ps

module bahc_law (
  input  bahc_pkg::cfg_t   cfg,
  input  bahc_pkg::item_t  item,
  input  bahc_pkg::state_t cur,
  output bahc_pkg::state_t nxt,
  output logic             hovering
);
  import bahc_pkg::*;

  logic signed [16:0] err;
  logic signed [16:0] band;
  logic signed [16:0] trans;
  logic signed [16:0] lim_wide;
  logic signed [11:0] lim;
  logic signed [8:0]  gain;
  logic signed [20:0] prod;
  logic signed [13:0] shr;
  logic signed [15:0] want;
  logic signed [15:0] comp_ext;
  logic signed [15:0] slewed;
  logic signed [15:0] lo_ext;
  logic signed [15:0] hi_ext;
  logic signed [15:0] limited;
  logic signed [15:0] roc_ext;
  logic signed [15:0] final_ext;
  logic signed [15:0] max_ext;
  logic [2:0]         cnt_law;
  logic signed [7:0]  comp_law;
  logic signed [7:0]  comp_decay;
  logic               run_law;

  // error against target, clamped to the band
  assign err   = $signed({item.altitude_cm[15], item.altitude_cm})
               - $signed({cur.target_altitude[15], cur.target_altitude});
  assign band  = $signed({6'd0, cfg.error_band_cm});
  assign trans = $signed({5'd0, cfg.descent_transition_cm});

  always_comb begin
    if (err < -band) begin
      lim_wide = -band;
    end else if (err > band) begin
      lim_wide = band;
    end else begin
      lim_wide = err;
    end
  end

  assign lim  = lim_wide[11:0];
  assign gain = $signed({1'b0, cfg.gain_kp});
  assign prod = 21'(lim * gain);
  // floor shift by 7 is the upper bits of the product
  assign shr  = prod[20:7];

  // descent counter
  assign roc_ext   = item.climb_rate;
  assign final_ext = 16'(cfg.final_descent_rate);
  assign max_ext   = 16'(cfg.max_descent_rate);

  always_comb begin
    if (err < band) begin
      cnt_law = (cur.descent_counter == 3'd0) ? 3'd0 : cur.descent_counter - 3'd1;
    end else if (((err < trans) && (roc_ext < final_ext)) || (roc_ext < max_ext)) begin
      cnt_law = (cur.descent_counter >= CNT_MAX) ? CNT_MAX : cur.descent_counter + 3'd1;
    end else begin
      cnt_law = (cur.descent_counter >= CNT_MAX) ? CNT_MAX : cur.descent_counter;
    end
  end

  // negated correction plus counter, slew step, then limits
  assign want     = -$signed({{2{shr[13]}}, shr}) + $signed({13'd0, cnt_law});
  assign comp_ext = 16'(cur.comp_value);
  assign lo_ext   = 16'(cfg.comp_low_limit);
  assign hi_ext   = 16'(cfg.comp_high_limit);

  always_comb begin
    if (want > comp_ext + 16'(SLEW_MAX)) begin
      slewed = comp_ext + 16'(SLEW_MAX);
    end else if (want < comp_ext - 16'(SLEW_MAX)) begin
      slewed = comp_ext - 16'(SLEW_MAX);
    end else begin
      slewed = want;
    end
    if (slewed < lo_ext) begin
      limited = lo_ext;
    end else if (slewed > hi_ext) begin
      limited = hi_ext;
    end else begin
      limited = slewed;
    end
  end

  assign comp_law = limited[7:0];

  always_comb begin
    if (cur.comp_value > 8'sd0) begin
      comp_decay = cur.comp_value - 8'sd1;
    end else if (cur.comp_value < 8'sd0) begin
      comp_decay = cur.comp_value + 8'sd1;
    end else begin
      comp_decay = cur.comp_value;
    end
  end

  // mode selection
  always_comb begin
    nxt     = cur;
    run_law = item.new_sample && item.altitude_valid;
    if (item.return_hold_mode && !item.holding_station) begin
      hovering = 1'b0;
    end else begin
      hovering = !item.throttle_moving;
    end
    if (item.return_hold_mode && !item.holding_station || hovering) begin
      if (run_law) begin
        nxt.descent_counter = cnt_law;
        nxt.comp_value      = comp_law;
      end
    end else begin
      nxt.target_altitude = item.altitude_cm;
      nxt.comp_value      = comp_decay;
    end
  end

endmodule

>>> design/baro_altitude_hold_controller.sv
// top level of the baro altitude hold controller: register file, input and result stages
// depends on bahc_pkg and bahc_law
`timescale 1ns / 1ps

// usage
// - in channel: one transaction per control tick; in_tdata carries altitude and climb rate
//   plus the mode flags, in_tuser says whether the sample is fresh and trustworthy
// - out channel: exactly one transaction per input transaction, in order, carrying the
//   throttle compensation, the hover flag and the target altitude after that tick
// - cfg port: one register written per cycle when cfg_wr_en is high; write only while idle
// - path: an accepted transaction is registered in the input stage, then its result is
//   registered in the result stage and offered from there on the out channel
// - throughput: one transaction per cycle unless stalled; the hold law is a single pass of
//   logic between the input stage and the result stage, and the controller state updates in
//   the same edge that loads the result, so the next tick sees it without a bubble
// - stall: the result stage holds its data while out_tready is low; one more transaction
//   is parked in the input stage, after which in_tready drops
// - reset: synchronous, active low; state clears to zero, registers take their defaults,
//   both stages empty
module baro_altitude_hold_controller (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // in channel
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // tdata: altitude_cm[15:0], climb_rate[31:16], return_hold_mode[32],
  //        holding_station[33], throttle_moving[34], zero pad[39:35]
  input  logic [bahc_pkg::IN_DATA_W-1:0]       in_tdata,
  // tuser: new_sample[0], altitude_valid[1]
  input  logic [bahc_pkg::IN_USER_W-1:0]       in_tuser,
  // out channel
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // tdata: throttle_comp[7:0], hovering[8], target_altitude_cm[24:9], zero pad[31:25]
  output logic [bahc_pkg::OUT_DATA_W-1:0]      out_tdata,
  // configuration write port
  input  logic                                 cfg_wr_en,
  input  logic [bahc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bahc_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import bahc_pkg::*;

  cfg_t   cfg_r;
  state_t state_r;
  state_t state_nxt;
  item_t  s1_item_r;
  logic   s1_valid_r;
  logic   out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic [OUT_DATA_W-1:0] out_data_nxt;
  logic   hovering;
  logic   advance;
  logic   in_fire;
  item_t  in_item;

  // unpack the incoming transaction
  always_comb begin
    in_item.altitude_cm      = in_tdata[15:0];
    in_item.climb_rate       = in_tdata[31:16];
    in_item.return_hold_mode = in_tdata[32];
    in_item.holding_station  = in_tdata[33];
    in_item.throttle_moving  = in_tdata[34];
    in_item.new_sample       = in_tuser[0];
    in_item.altitude_valid   = in_tuser[1];
  end

  // input stage moves on when the result stage is empty or being drained
  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;
  assign in_fire   = in_tvalid && in_tready;

  bahc_law u_law (
    .cfg      (cfg_r),
    .item     (s1_item_r),
    .cur      (state_r),
    .nxt      (state_nxt),
    .hovering (hovering)
  );

  assign out_data_nxt = {7'd0, state_nxt.target_altitude, hovering, state_nxt.comp_value};

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_kp               <= RST_GAIN_KP;
      cfg_r.error_band_cm         <= RST_ERROR_BAND;
      cfg_r.descent_transition_cm <= RST_DESCENT_TRANS;
      cfg_r.final_descent_rate    <= RST_FINAL_DESCENT;
      cfg_r.max_descent_rate      <= RST_MAX_DESCENT;
      cfg_r.comp_low_limit        <= RST_COMP_LOW_LIMIT;
      cfg_r.comp_high_limit       <= RST_COMP_HIGH_LIMIT;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_GAIN_KP:         cfg_r.gain_kp               <= cfg_wdata[7:0];
        REG_ERROR_BAND:      cfg_r.error_band_cm         <= cfg_wdata[10:0];
        REG_DESCENT_TRANS:   cfg_r.descent_transition_cm <= cfg_wdata;
        REG_FINAL_DESCENT:   cfg_r.final_descent_rate    <= cfg_wdata;
        REG_MAX_DESCENT:     cfg_r.max_descent_rate      <= cfg_wdata;
        REG_COMP_LOW_LIMIT:  cfg_r.comp_low_limit        <= cfg_wdata[7:0];
        REG_COMP_HIGH_LIMIT: cfg_r.comp_high_limit       <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // input stage: control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  // input stage: payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r <= in_item;
    end
  end

  // controller state commits together with the result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  // result stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

>>> verif/baro_altitude_hold_controller_test.sv
// self-checking bench for baro_altitude_hold_controller: directed and random control ticks,
// each result checked against an in-bench model of the altitude hold law
// depends on bahc_pkg and the design sources under design/
`timescale 1ns / 1ps

module baro_altitude_hold_controller_test;
  import bahc_pkg::*;

  // one result transaction, field for field
  typedef struct packed {
    logic signed [7:0]  throttle_comp;
    logic               hovering;
    logic signed [15:0] target_altitude_cm;
  } hold_result_t;

  // cycles with no transaction on either channel before the run is declared hung
  localparam int IDLE_LIMIT         = 2000;
  // pause after the last result, two-stage pipe plus margin
  localparam int SETTLE_CYCLES      = 8;
  localparam int RANDOM_PER_SETTING = 72;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  // tdata: altitude_cm[15:0], climb_rate[31:16], return_hold_mode[32],
  //        holding_station[33], throttle_moving[34], zero pad[39:35]
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  // tuser: new_sample[0], altitude_valid[1]
  logic [IN_USER_W-1:0]  in_tuser   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // tdata: throttle_comp[7:0], hovering[8], target_altitude_cm[24:9], zero pad[31:25]
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_wr_en  = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;

  // register copies of the model, kept as plain integers
  int model_gain  = int'(RST_GAIN_KP);
  int model_band  = int'(RST_ERROR_BAND);
  int model_trans = int'(RST_DESCENT_TRANS);
  int model_final = int'(RST_FINAL_DESCENT);
  int model_max   = int'(RST_MAX_DESCENT);
  int model_low   = int'(RST_COMP_LOW_LIMIT);
  int model_high  = int'(RST_COMP_HIGH_LIMIT);

  // controller state of the model, all zero after reset
  int comp_now      = 0;
  int descent_count = 0;
  int target_now    = 0;

  // target the stimulus side expects, so random altitudes land near it
  int gen_target = 0;

  item_t        pending_ticks[$];      // ticks waiting to go onto the input channel
  hold_result_t predicted_results[$];  // results owed by the block, oldest first
  item_t        tick_on_bus;
  hold_result_t result_due;
  logic         offer;

  int send_idle_pct  = 0;
  int stall_pct      = 0;
  int mismatch_count = 0;
  int idle_cycles    = 0;

  baro_altitude_hold_controller DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #1 clk = ~clk;

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // register write as the block sees it: only the low bits of each register count
  function automatic void apply_register(logic [CFG_IDX_W-1:0] idx,
                                         logic [CFG_DATA_W-1:0] v);
    case (idx)
      REG_GAIN_KP:         model_gain  = int'(v[7:0]);
      REG_ERROR_BAND:      model_band  = int'(v[10:0]);
      REG_DESCENT_TRANS:   model_trans = int'(v);
      REG_FINAL_DESCENT:   model_final = int'($signed(v));
      REG_MAX_DESCENT:     model_max   = int'($signed(v));
      REG_COMP_LOW_LIMIT:  model_low   = int'($signed(v[7:0]));
      REG_COMP_HIGH_LIMIT: model_high  = int'($signed(v[7:0]));
      default: ;
    endcase
  endfunction

  // one fresh valid sample in hold: clamp, gain, descent counter, slew, limits
  function automatic void apply_hold_law(int alt, int roc);
    int err;
    int lim;
    int want;
    err = alt - target_now;
    lim = err;
    if (lim < -model_band) lim = -model_band;
    else if (lim > model_band) lim = model_band;
    // arithmetic shift on a signed int floors, as the block does
    want = -((lim * model_gain) >>> 7);
    // near the target the counter bleeds off, far above it grows on fast descent
    if (err < model_band) begin
      if (descent_count > 0) descent_count--;
    end else if ((err < model_trans && roc < model_final) || roc < model_max) begin
      descent_count++;
    end
    if (descent_count > int'(CNT_MAX)) descent_count = int'(CNT_MAX);
    want += descent_count;
    if (want > comp_now + SLEW_MAX) want = comp_now + SLEW_MAX;
    else if (want < comp_now - SLEW_MAX) want = comp_now - SLEW_MAX;
    // crossed limits: below low gives low, anything else gives high
    if (want < model_low) want = model_low;
    else if (want > model_high) want = model_high;
    comp_now = want;
  endfunction

  function automatic hold_result_t predict_tick(item_t t);
    hold_result_t r;
    logic         law_mode;
    logic         hover;
    law_mode = t.return_hold_mode && !t.holding_station;
    hover    = !law_mode && !t.throttle_moving;
    if (law_mode || hover) begin
      if (t.new_sample && t.altitude_valid)
        apply_hold_law(int'($signed(t.altitude_cm)), int'($signed(t.climb_rate)));
    end else begin
      // pilot on the stick: target follows, compensation decays one step
      target_now = int'($signed(t.altitude_cm));
      if (comp_now > 0) comp_now--;
      else if (comp_now < 0) comp_now++;
    end
    r.throttle_comp      = 8'(comp_now);
    r.hovering           = hover;
    r.target_altitude_cm = 16'(target_now);
    return r;
  endfunction

  function automatic item_t compose_tick(int alt, int roc, logic fresh, logic valid,
                                         logic rth, logic station, logic moving);
    item_t t;
    t.altitude_cm      = 16'(alt);
    t.climb_rate       = 16'(roc);
    t.new_sample       = fresh;
    t.altitude_valid   = valid;
    t.return_hold_mode = rth;
    t.holding_station  = station;
    t.throttle_moving  = moving;
    if (!(rth && !station) && moving) gen_target = int'($signed(t.altitude_cm));
    return t;
  endfunction

  // mostly hold ticks with fresh samples around the target, some stick moves and noise
  function automatic item_t random_tick(int band);
    int   pick;
    int   span;
    int   alt;
    int   roc;
    logic fresh;
    logic valid;
    logic rth;
    logic station;
    logic moving;
    pick    = $urandom_range(99);
    rth     = 1'($urandom);
    station = 1'($urandom);
    moving  = 1'($urandom);
    if (pick < 45) begin
      rth     = 1'b1;
      station = 1'b0;
    end else if (pick < 80) begin
      station = 1'b1;
      moving  = 1'b0;
    end else if (pick < 92) begin
      station = 1'b1;
      moving  = 1'b1;
    end
    fresh = 1'b1;
    valid = 1'b1;
    if ($urandom_range(99) < 15) begin
      fresh = 1'($urandom);
      valid = 1'($urandom);
    end
    span = 3 * band + 20;
    if ($urandom_range(9) < 8) begin
      alt = gen_target + int'($urandom_range(2 * span)) - span;
      if (alt > 32767) alt = 32767;
      else if (alt < -32768) alt = -32768;
    end else begin
      alt = int'($signed(16'($urandom)));
    end
    pick = $urandom_range(9);
    if (pick < 5) roc = int'($urandom_range(4400)) - 2200;
    else if (pick < 7) roc = int'($urandom_range(200)) - 150;
    else roc = int'($signed(16'($urandom)));
    return compose_tick(alt, roc, fresh, valid, rth, station, moving);
  endfunction

  // the model takes the value at once; no tick is in flight while registers change
  task automatic write_register(logic [CFG_IDX_W-1:0] idx, int value);
    logic [CFG_DATA_W-1:0] v;
    v = value[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    apply_register(idx, v);
  endtask

  task automatic load_setting(int gain, int band, int trans, int fin, int mx,
                              int lo, int hi);
    write_register(REG_GAIN_KP, gain);
    write_register(REG_ERROR_BAND, band);
    write_register(REG_DESCENT_TRANS, trans);
    write_register(REG_FINAL_DESCENT, fin);
    write_register(REG_MAX_DESCENT, mx);
    write_register(REG_COMP_LOW_LIMIT, lo);
    write_register(REG_COMP_HIGH_LIMIT, hi);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_ticks.size() != 0 || in_tvalid || predicted_results.size() != 0)
      @(negedge clk);
  endtask

  // input driver: prediction is taken at the edge that accepts the transaction
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid) predicted_results.push_back(predict_tick(tick_on_bus));
      offer = pending_ticks.size() != 0 && $urandom_range(99) >= send_idle_pct;
      if (offer) begin
        tick_on_bus = pending_ticks.pop_front();
        in_tdata <= {tick_on_bus.throttle_moving, tick_on_bus.holding_station,
                     tick_on_bus.return_hold_mode, tick_on_bus.climb_rate,
                     tick_on_bus.altitude_cm};
        in_tuser <= {tick_on_bus.altitude_valid, tick_on_bus.new_sample};
      end
      in_tvalid <= offer;
    end
  end

  // result side back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= $urandom_range(99) >= stall_pct;
    end
  end

  // result monitor: each accepted transaction against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (predicted_results.size() == 0) begin
        report_mismatch($sformatf("result with no tick outstanding, data %h", out_tdata));
      end else begin
        result_due = predicted_results.pop_front();
        if (out_tdata[7:0] !== result_due.throttle_comp)
          report_mismatch($sformatf("throttle_comp %0d, expected %0d",
                                    $signed(out_tdata[7:0]),
                                    result_due.throttle_comp));
        if (out_tdata[8] !== result_due.hovering)
          report_mismatch($sformatf("hovering %b, expected %b",
                                    out_tdata[8], result_due.hovering));
        if (out_tdata[24:9] !== result_due.target_altitude_cm)
          report_mismatch($sformatf("target_altitude_cm %0d, expected %0d",
                                    $signed(out_tdata[24:9]),
                                    result_due.target_altitude_cm));
      end
    end
  end

  // hang detector: counts cycles in which neither channel moves a transaction
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("baro_altitude_hold_controller test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed ticks on reset register values, no idling on either side
    // stick moving while holding station: target jumps to 1000
    pending_ticks.push_back(compose_tick(1000, 0, 1, 1, 0, 1, 1));
    // return hold exactly on target
    pending_ticks.push_back(compose_tick(1000, 0, 1, 1, 1, 0, 0));
    // far above target, sinking faster than the max descent rate: counter grows
    pending_ticks.push_back(compose_tick(1500, -200, 1, 1, 1, 0, 0));
    // above band but inside transition, sinking past the final rate: counter grows
    pending_ticks.push_back(compose_tick(1500, -60, 1, 1, 1, 0, 0));
    // beyond transition, slow sink: counter holds
    pending_ticks.push_back(compose_tick(2500, -60, 1, 1, 1, 0, 0));
    // altitude and climb rate at their extremes: counter saturates at its ceiling,
    // compensation slews down onto the low limit
    repeat (6) pending_ticks.push_back(compose_tick(32767, -32768, 1, 1, 1, 0, 0));
    // far below target: counter bleeds off, compensation slews up
    pending_ticks.push_back(compose_tick(-32768, 32767, 1, 1, 1, 0, 0));
    // stale sample, then untrusted sample: state untouched
    pending_ticks.push_back(compose_tick(0, 0, 0, 1, 1, 0, 0));
    pending_ticks.push_back(compose_tick(0, 0, 1, 0, 1, 0, 0));
    // hovering on station
    pending_ticks.push_back(compose_tick(-32768, -32768, 1, 1, 0, 1, 0));
    // return hold while on station counts as station holding
    pending_ticks.push_back(compose_tick(500, 0, 1, 1, 1, 1, 0));
    pending_ticks.push_back(compose_tick(700, 0, 1, 1, 1, 1, 1));
    // no mode flags at all: hovering unless the stick moves
    pending_ticks.push_back(compose_tick(700, 0, 1, 1, 0, 0, 0));
    pending_ticks.push_back(compose_tick(900, 0, 1, 1, 0, 0, 1));
    pending_ticks.push_back(compose_tick(32767, 32767, 0, 0, 0, 0, 1));
    pending_ticks.push_back(compose_tick(-32768, -32768, 1, 1, 0, 0, 1));
    // error spanning the whole altitude range
    pending_ticks.push_back(compose_tick(32767, 0, 1, 1, 0, 1, 0));
    // compensation decays toward zero
    repeat (2) pending_ticks.push_back(compose_tick(0, 0, 1, 1, 0, 1, 1));
    wait_drained();

    for (int s = 0; s < 7; s++) begin
      repeat (SETTLE_CYCLES) @(posedge clk);
      case (s)
        0: load_setting(16, 200, 1000, -50, -100, -10, 30);
        // every register at its top end, the low limit at its bottom end
        1: load_setting(255, 2047, 4095, 2047, 2047, -128, 127);
        // bottom ends, limits crossed
        2: load_setting(0, 0, 0, -2048, -2048, 127, -128);
        3: load_setting(200, 50, 300, -20, -400, -40, 40);
        // single-value window, one-cm band
        5: load_setting(128, 1, 4095, -2048, 2047, 0, 0);
        default: load_setting($urandom_range(255), $urandom_range(2047),
                              $urandom_range(4095), int'($urandom_range(4095)) - 2048,
                              int'($urandom_range(4095)) - 2048,
                              int'($urandom_range(255)) - 128,
                              int'($urandom_range(255)) - 128);
      endcase
      @(negedge clk);
      // idling pattern rotates: sender idle, receiver stall, both light, none
      case ((s + 1) % 4)
        1: begin
          send_idle_pct = 88;
          stall_pct     = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 88;
        end
        3: begin
          send_idle_pct = 9;
          stall_pct     = 9;
        end
        default: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
      endcase
      repeat (RANDOM_PER_SETTING) pending_ticks.push_back(random_tick(model_band));
      wait_drained();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("baro_altitude_hold_controller test passed");
    end else begin
      $display("baro_altitude_hold_controller test failed");
    end
    $finish;
  end

endmodule
